// ----- hdl/rau_pkg.sv -----
// Shared constants and types for the rational arithmetic unit.
package rau_pkg;

    localparam int ValueWidth = 32;
    localparam int DenWidth   = ValueWidth - 1;
    localparam int WideWidth  = 2 * ValueWidth;
    localparam int CntWidth   = $clog2(WideWidth + 1);

    typedef enum logic [2:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_LT  = 3'd4,
        CMD_EQ  = 3'd5
    } cmd_t;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIVZERO  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // one queued task from front to back
    typedef struct packed {
        logic [2:0]                  command;
        logic                        early;   // result already known
        logic [1:0]                  early_st;
        logic signed [ValueWidth-1:0] an;
        logic [DenWidth-1:0]         ad;
        logic signed [ValueWidth-1:0] bn;
        logic [DenWidth-1:0]         bd;
    } task_t;

endpackage

// ----- hdl/rational_arithmetic_unit.sv -----
// Top level: rational add, subtract, multiply, divide and compare.
// Sequence: trivial cases finish in the idle state; comparisons pass through S_MUL, S_COMB
// and S_OUT; a zero arithmetic result leaves S_GCD for S_OUT; other arithmetic runs the
// one-step binary GCD loop, S_GSHIFT and two 64-step bit-serial divisions, then S_CHECK.
// Throughput: one item at a time in the back end; a two-entry queue takes further
// commands meanwhile. Results appear one cycle each on done and cannot be stalled.
// Reset: asynchronous, active low; clears the queue and returns the back end to idle.
module rational_arithmetic_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             command,
    input  logic signed [rau_pkg::ValueWidth-1:0]  a_num,
    input  logic [rau_pkg::DenWidth-1:0]           a_den,
    input  logic signed [rau_pkg::ValueWidth-1:0]  b_num,
    input  logic [rau_pkg::DenWidth-1:0]           b_den,
    output logic                                   done,
    output logic signed [rau_pkg::ValueWidth-1:0]  res_num,
    output logic [rau_pkg::DenWidth-1:0]           res_den,
    output logic                                   compare_true,
    output logic [1:0]                             status
);
    logic           q_valid, q_pop;
    rau_pkg::task_t q_task;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .a_num(a_num), .a_den(a_den),
        .b_num(b_num), .b_den(b_den),
        .q_valid(q_valid), .q_task(q_task), .q_pop(q_pop)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_task(q_task), .q_pop(q_pop),
        .done(done), .res_num(res_num), .res_den(res_den),
        .compare_true(compare_true), .status(status)
    );
endmodule

// ----- hdl/rau_front.sv -----
// Front end: takes in commands and classifies the trivial cases.
module rau_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [2:0]                             command,
    input  logic signed [rau_pkg::ValueWidth-1:0]  a_num,
    input  logic [rau_pkg::DenWidth-1:0]           a_den,
    input  logic signed [rau_pkg::ValueWidth-1:0]  b_num,
    input  logic [rau_pkg::DenWidth-1:0]           b_den,
    output logic                                   q_valid,
    output rau_pkg::task_t                         q_task,
    input  logic                                   q_pop
);
    // two-entry queue
    rau_pkg::task_t mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    rau_pkg::task_t t;
    logic push;

    always_comb
    begin
        t.command  = command;
        t.an       = a_num;
        t.ad       = a_den;
        t.bn       = b_num;
        t.bd       = b_den;
        t.early    = 1'b0;
        t.early_st = rau_pkg::ST_OK;
        if (command > rau_pkg::CMD_EQ)
        begin
            t.early = 1'b1;
        end
        else if (a_den == '0 || b_den == '0)
        begin
            t.early = 1'b1;
            t.early_st = rau_pkg::ST_DIVZERO;
        end
        else if (command == rau_pkg::CMD_DIV && b_num == '0)
        begin
            t.early = 1'b1;
            t.early_st = rau_pkg::ST_DIVZERO;
        end
    end

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_task  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= t;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end
endmodule

// ----- hdl/rau_back.sv -----
// Back end: cross products, binary GCD and reducing divisions.
module rau_back (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   q_valid,
    input  rau_pkg::task_t                         q_task,
    output logic                                   q_pop,
    output logic                                   done,
    output logic signed [rau_pkg::ValueWidth-1:0]  res_num,
    output logic [rau_pkg::DenWidth-1:0]           res_den,
    output logic                                   compare_true,
    output logic [1:0]                             status
);
    localparam int W = rau_pkg::WideWidth;
    localparam int V = rau_pkg::ValueWidth;
    localparam int C = rau_pkg::CntWidth;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_COMB, S_GCD, S_GSHIFT, S_DIVN, S_DIVD, S_CHECK, S_OUT
    } state_t;

    state_t state_reg;
    logic [2:0] cmd_reg;
    logic signed [V-1:0] an_reg, bn_reg;
    logic [V-1:0] ad_reg, bd_reg;
    logic signed [W-1:0] x_reg, y_reg;
    logic [W-1:0] den_reg, nmag_reg, gu_reg, gv_reg, g_reg;
    logic [C-1:0] k_reg, cnt_reg;
    logic neg_reg;
    // divider
    logic [W-1:0] quo_reg, rem_reg, dvd_reg;
    logic done_reg, cmp_reg;
    logic [1:0] st_reg;
    logic signed [V-1:0] rn_reg;
    logic [V-2:0] rd_reg;

    logic [V-1:0] amag, bmag;
    logic signed [W-1:0] nsum;
    logic [W:0] trial;
    logic [W-1:0] lim, gdiff;

    assign amag  = an_reg[V-1] ? V'(-an_reg) : V'(an_reg);
    assign bmag  = bn_reg[V-1] ? V'(-bn_reg) : V'(bn_reg);
    assign nsum  = (cmd_reg == rau_pkg::CMD_SUB) ? x_reg - y_reg : x_reg + y_reg;
    assign trial = {rem_reg, dvd_reg[W-1]} - {1'b0, g_reg};
    assign lim   = W'(1) << (V - 1);
    assign gdiff = (gu_reg > gv_reg) ? gu_reg - gv_reg : gv_reg - gu_reg;
    assign q_pop = (state_reg == S_IDLE) && q_valid;

    assign done = done_reg;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign compare_true = cmp_reg;
    assign status = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg) inside
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cmd_reg <= q_task.command;
                        an_reg  <= q_task.an;
                        bn_reg  <= q_task.bn;
                        ad_reg  <= {1'b0, q_task.ad};
                        bd_reg  <= {1'b0, q_task.bd};
                        if (q_task.early)
                        begin
                            rn_reg   <= '0;
                            rd_reg   <= (V-1)'(1);
                            cmp_reg  <= 1'b0;
                            st_reg   <= q_task.early_st;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_MUL;
                        end
                    end
                end
                S_MUL:
                begin
                    // operand products, one per multiplier
                    unique case (cmd_reg)
                        rau_pkg::CMD_MUL:
                        begin
                            x_reg <= W'(amag) * W'(bmag);
                            neg_reg <= an_reg[V-1] ^ bn_reg[V-1];
                            den_reg <= W'(ad_reg) * W'(bd_reg);
                        end
                        rau_pkg::CMD_DIV:
                        begin
                            x_reg <= W'(amag) * W'(bd_reg);
                            neg_reg <= an_reg[V-1] ^ bn_reg[V-1];
                            den_reg <= W'(ad_reg) * W'(bmag);
                        end
                        default:
                        begin
                            x_reg <= W'(an_reg) * $signed(W'(bd_reg));
                            y_reg <= W'(bn_reg) * $signed(W'(ad_reg));
                            den_reg <= W'(ad_reg) * W'(bd_reg);
                        end
                    endcase
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    if (cmd_reg == rau_pkg::CMD_LT || cmd_reg == rau_pkg::CMD_EQ)
                    begin
                        rn_reg  <= '0;
                        rd_reg  <= (V-1)'(1);
                        st_reg  <= rau_pkg::ST_OK;
                        cmp_reg <= (cmd_reg == rau_pkg::CMD_LT) ? (x_reg < y_reg)
                                                                 : (x_reg == y_reg);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        if (cmd_reg == rau_pkg::CMD_ADD || cmd_reg == rau_pkg::CMD_SUB)
                        begin
                            neg_reg  <= nsum[W-1];
                            nmag_reg <= nsum[W-1] ? W'(-nsum) : W'(nsum);
                            gu_reg   <= nsum[W-1] ? W'(-nsum) : W'(nsum);
                        end
                        else
                        begin
                            nmag_reg <= x_reg;
                            gu_reg   <= x_reg;
                        end
                        gv_reg <= den_reg;
                        k_reg  <= '0;
                        state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    // binary GCD, one step a cycle; den is never zero
                    if (nmag_reg == '0)
                    begin
                        rn_reg  <= '0;
                        rd_reg  <= (V-1)'(1);
                        cmp_reg <= 1'b0;
                        st_reg  <= rau_pkg::ST_OK;
                        state_reg <= S_OUT;
                    end
                    else if (gu_reg == '0)
                    begin
                        g_reg <= gv_reg;
                        state_reg <= S_GSHIFT;
                    end
                    else if (!gu_reg[0] && !gv_reg[0])
                    begin
                        gu_reg <= gu_reg >> 1;
                        gv_reg <= gv_reg >> 1;
                        k_reg  <= k_reg + C'(1);
                    end
                    else if (!gu_reg[0])
                    begin
                        gu_reg <= gu_reg >> 1;
                    end
                    else if (!gv_reg[0])
                    begin
                        gv_reg <= gv_reg >> 1;
                    end
                    else
                    begin
                        gu_reg <= gdiff;
                        gv_reg <= (gu_reg < gv_reg) ? gu_reg : gv_reg;
                    end
                end
                S_GSHIFT:
                begin
                    if (k_reg == '0)
                    begin
                        dvd_reg <= nmag_reg;
                        rem_reg <= '0;
                        cnt_reg <= C'(W);
                        state_reg <= S_DIVN;
                    end
                    else
                    begin
                        g_reg <= g_reg << 1;
                        k_reg <= k_reg - C'(1);
                    end
                end
                S_DIVN, S_DIVD:
                begin
                    // restoring division, one quotient bit a cycle
                    if (cnt_reg == '0)
                    begin
                        if (state_reg == S_DIVN)
                        begin
                            nmag_reg <= quo_reg;
                            dvd_reg  <= den_reg;
                            rem_reg  <= '0;
                            cnt_reg  <= C'(W);
                            state_reg <= S_DIVD;
                        end
                        else
                        begin
                            den_reg <= quo_reg;
                            state_reg <= S_CHECK;
                        end
                    end
                    else
                    begin
                        if (!trial[W])
                        begin
                            rem_reg <= trial[W-1:0];
                            quo_reg <= {quo_reg[W-2:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[W-2:0], dvd_reg[W-1]};
                            quo_reg <= {quo_reg[W-2:0], 1'b0};
                        end
                        dvd_reg <= dvd_reg << 1;
                        cnt_reg <= cnt_reg - C'(1);
                    end
                end
                S_CHECK:
                begin
                    cmp_reg <= 1'b0;
                    if (den_reg > lim - W'(1)
                        || (neg_reg ? nmag_reg > lim : nmag_reg > lim - W'(1)))
                    begin
                        rn_reg <= '0;
                        rd_reg <= (V-1)'(1);
                        st_reg <= rau_pkg::ST_OVERFLOW;
                    end
                    else
                    begin
                        rn_reg <= neg_reg ? V'(-nmag_reg) : V'(nmag_reg);
                        rd_reg <= den_reg[V-2:0];
                        st_reg <= rau_pkg::ST_OK;
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the rational arithmetic unit.
module testbench;

    localparam int CycleLimit = 2000000;
    localparam int DrainCycles = 400;
    localparam logic [2:0] CmdSpare6 = 3'd6;
    localparam logic [2:0] CmdSpare7 = 3'd7;

    typedef struct {
        logic signed [rau_pkg::ValueWidth-1:0] num;
        logic [rau_pkg::DenWidth-1:0]          den;
        logic                                  cmp;
        logic [1:0]                            st;
    } rational_result_t;

    logic                                   clk;
    logic                                   rst_n;
    logic                                   start;
    logic                                   busy;
    logic [2:0]                             command;
    logic signed [rau_pkg::ValueWidth-1:0]  a_num;
    logic [rau_pkg::DenWidth-1:0]           a_den;
    logic signed [rau_pkg::ValueWidth-1:0]  b_num;
    logic [rau_pkg::DenWidth-1:0]           b_den;
    logic                                   done;
    logic signed [rau_pkg::ValueWidth-1:0]  res_num;
    logic [rau_pkg::DenWidth-1:0]           res_den;
    logic                                   compare_true;
    logic [1:0]                             status;

    rational_result_t pending_results[$];
    int  errors;
    longint cycle_count;

    rational_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .command(command),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den), .done(done),
        .res_num(res_num), .res_den(res_den), .compare_true(compare_true),
        .status(status)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    // bring sign/magnitude over den to lowest terms and range-check it
    function automatic rational_result_t reduce_fraction(logic neg, logic [63:0] nmag,
                                                        logic [63:0] den);
        rational_result_t r;
        logic [63:0] g;
        logic [63:0] lim;
        r = '{num: '0, den: 1, cmp: 1'b0, st: rau_pkg::ST_OK};
        if (nmag == 0)
            return r;
        g = gcd64(nmag, den);
        nmag = nmag / g;
        den = den / g;
        lim = 64'd1 << (rau_pkg::ValueWidth - 1);
        if (den > lim - 1 || (neg ? nmag > lim : nmag > lim - 1))
        begin
            r.st = rau_pkg::ST_OVERFLOW;
            return r;
        end
        r.num = neg ? rau_pkg::ValueWidth'(-nmag) : rau_pkg::ValueWidth'(nmag);
        r.den = rau_pkg::DenWidth'(den);
        return r;
    endfunction

    function automatic rational_result_t predict_rational(logic [2:0] cmd,
            logic signed [rau_pkg::ValueWidth-1:0] an_in, logic [rau_pkg::DenWidth-1:0] ad_in,
            logic signed [rau_pkg::ValueWidth-1:0] bn_in, logic [rau_pkg::DenWidth-1:0] bd_in);
        rational_result_t r;
        longint an, ad, bn, bd, x, y, n;
        an = an_in;
        ad = ad_in;
        bn = bn_in;
        bd = bd_in;
        r = '{num: '0, den: 1, cmp: 1'b0, st: rau_pkg::ST_OK};
        if (cmd > rau_pkg::CMD_EQ)
            return r;
        if (ad == 0 || bd == 0)
        begin
            r.st = rau_pkg::ST_DIVZERO;
            return r;
        end
        x = an * bd;
        y = bn * ad;
        case (cmd)
            rau_pkg::CMD_ADD:
            begin
                n = x + y;
                r = reduce_fraction(n < 0, magnitude(n), 64'(ad) * 64'(bd));
            end
            rau_pkg::CMD_SUB:
            begin
                n = x - y;
                r = reduce_fraction(n < 0, magnitude(n), 64'(ad) * 64'(bd));
            end
            rau_pkg::CMD_MUL:
                r = reduce_fraction((an < 0) != (bn < 0), magnitude(an) * magnitude(bn),
                                    64'(ad) * 64'(bd));
            rau_pkg::CMD_DIV:
                if (bn == 0)
                    r.st = rau_pkg::ST_DIVZERO;
                else
                    r = reduce_fraction((an < 0) != (bn < 0), magnitude(an) * 64'(bd),
                                        64'(ad) * magnitude(bn));
            rau_pkg::CMD_LT:
                r.cmp = x < y;
            default:
                r.cmp = x == y;
        endcase
        return r;
    endfunction

    // one transfer; the expectation is queued at the accepting edge
    // start stays high after the transfer until the next item or the end
    task automatic send_item(logic [2:0] cmd, logic signed [rau_pkg::ValueWidth-1:0] an,
                             logic [rau_pkg::DenWidth-1:0] ad,
                             logic signed [rau_pkg::ValueWidth-1:0] bn,
                             logic [rau_pkg::DenWidth-1:0] bd, int gap);
        rational_result_t exp_item;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        a_num <= an;
        a_den <= ad;
        b_num <= bn;
        b_den <= bd;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        exp_item = predict_rational(cmd, an, ad, bn, bd);
        pending_results = {pending_results, exp_item};
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        rational_result_t exp_r;
        cycle_count <= cycle_count + 1;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no expectation: %0d/%0d", res_num, res_den);
                errors++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (res_num !== exp_r.num)
                begin
                    $error("res_num expected %0d actual %0d", exp_r.num, res_num);
                    errors++;
                end
                if (res_den !== exp_r.den)
                begin
                    $error("res_den expected %0d actual %0d", exp_r.den, res_den);
                    errors++;
                end
                if (compare_true !== exp_r.cmp)
                begin
                    $error("compare_true expected %0d actual %0d", exp_r.cmp, compare_true);
                    errors++;
                end
                if (status !== exp_r.st)
                begin
                    $error("status expected %0d actual %0d", exp_r.st, status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("rational_arithmetic_unit verification failed");
            $finish;
        end
    end

    function automatic logic signed [rau_pkg::ValueWidth-1:0] rand_num();
        case ($urandom_range(0, 3))
            0: return $signed(rau_pkg::ValueWidth'($urandom_range(0, 40))) - 20;
            1: return $signed(rau_pkg::ValueWidth'($urandom_range(0, 2000))) - 1000;
            2: return $signed(rau_pkg::ValueWidth'($urandom_range(0, 131072))) - 65536;
            default: return $signed(rau_pkg::ValueWidth'($urandom()));
        endcase
    endfunction

    function automatic logic [rau_pkg::DenWidth-1:0] rand_den();
        case ($urandom_range(0, 3))
            0: return rau_pkg::DenWidth'($urandom_range(1, 30));
            1: return rau_pkg::DenWidth'($urandom_range(1, 3000));
            2: return rau_pkg::DenWidth'($urandom_range(1, 70000));
            default: return rau_pkg::DenWidth'($urandom()) | rau_pkg::DenWidth'(1);
        endcase
    endfunction

    task automatic test_extremes();
        logic signed [rau_pkg::ValueWidth-1:0] nmax, nmin;
        logic [rau_pkg::DenWidth-1:0] dmax;
        nmax = {1'b0, {(rau_pkg::ValueWidth-1){1'b1}}};
        nmin = {1'b1, {(rau_pkg::ValueWidth-1){1'b0}}};
        dmax = '1;
        send_item(rau_pkg::CMD_ADD, 1, 2, 1, 3, 0);
        send_item(rau_pkg::CMD_SUB, 1, 2, 1, 2, 0);
        send_item(rau_pkg::CMD_MUL, -3, 4, 4, 9, 0);
        send_item(rau_pkg::CMD_DIV, 5, 7, -10, 21, 0);
        send_item(rau_pkg::CMD_LT, -1, 3, 1, 3, 0);
        send_item(rau_pkg::CMD_EQ, 2, 4, 1, 2, 0);   // unreduced operand
        send_item(rau_pkg::CMD_DIV, 3, 4, 0, 1, 0);  // divide by zero value
        send_item(rau_pkg::CMD_ADD, 1, 0, 1, 1, 0);  // zero denominators
        send_item(rau_pkg::CMD_LT, 1, 1, 1, 0, 0);
        send_item(rau_pkg::CMD_EQ, 0, 0, 0, 0, 0);
        send_item(CmdSpare6, 5, 3, 2, 1, 0);
        send_item(CmdSpare7, nmin, dmax, nmax, 0, 0);
        send_item(rau_pkg::CMD_ADD, nmax, 1, nmax, 1, 0);   // overflow
        send_item(rau_pkg::CMD_SUB, nmin, 1, 1, 1, 0);
        send_item(rau_pkg::CMD_MUL, nmin, 1, -1, 1, 0);
        send_item(rau_pkg::CMD_MUL, nmin, 1, 1, 1, 0);
        send_item(rau_pkg::CMD_DIV, 1, dmax, 1, dmax, 0);
        send_item(rau_pkg::CMD_DIV, 1, dmax, 2, 1, 0);      // denominator overflow
        send_item(rau_pkg::CMD_ADD, nmax, dmax, nmin, dmax, 0);
        send_item(rau_pkg::CMD_LT, nmin, 1, nmax, 1, 0);
        send_item(rau_pkg::CMD_EQ, nmax, dmax, nmax, dmax, 0);
        send_item(rau_pkg::CMD_LT, nmax, dmax, nmin, dmax, 0);
        send_item(rau_pkg::CMD_ADD, -1, 1, 1, 1, 0);
    endtask

    task automatic test_random(int count);
        logic [2:0] cmd;
        logic [rau_pkg::DenWidth-1:0] ad, bd;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(0, 7))
                                               : 3'($urandom_range(0, 5));
            ad = rand_den();
            bd = rand_den();
            if ($urandom_range(0, 39) == 0)
                ad = 0;
            if ($urandom_range(0, 39) == 0)
                bd = 0;
            // runs without gaps keep the input queue full
            send_item(cmd, rand_num(), ad, ($urandom_range(0, 15) == 0) ? '0 : rand_num(),
                      bd, (i % 100 < 20) ? 0 : $urandom_range(0, 4));
        end
    endtask

    initial
    begin
        errors = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        command = rau_pkg::CMD_ADD;
        a_num = '0;
        a_den = 1;
        b_num = '0;
        b_den = 1;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_extremes();
        test_random(900);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("rational_arithmetic_unit verification clean");
        else
            $display("rational_arithmetic_unit verification failed");
        $finish;
    end
endmodule

// ----- rational_arithmetic_unit.f -----
hdl/rau_pkg.sv
hdl/rau_front.sv
hdl/rau_back.sv
hdl/rational_arithmetic_unit.sv
tb/testbench.sv
